// ----- src/pbt_pkg.sv -----
// ----------------------------------------------------------------------------
// pbt_pkg
// Shared types, character codes and byte classifiers for the PGN tokenizer.
// ----------------------------------------------------------------------------
package pbt_pkg;

   // lexer mode between bytes
   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_STRING = 2'd1,
      MODE_NAG    = 2'd2,
      MODE_WORD   = 2'd3
   } mode_type;

   // token kinds as they appear on the result channel
   typedef enum logic [3:0] {
      KIND_STRING   = 4'd0,
      KIND_PERIOD   = 4'd1,
      KIND_ASTERISK = 4'd2,
      KIND_LBRACKET = 4'd3,
      KIND_RBRACKET = 4'd4,
      KIND_LPAREN   = 4'd5,
      KIND_RPAREN   = 4'd6,
      KIND_LANGLE   = 4'd7,
      KIND_RANGLE   = 4'd8,
      KIND_NAG      = 4'd9,
      KIND_INTEGER  = 4'd10,
      KIND_SYMBOL   = 4'd11,
      KIND_END      = 4'd12
   } kind_type;

   // character codes
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_UNDERLINE = 8'h5F;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_EQUAL     = 8'h3D;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_PERIOD    = 8'h2E;
   localparam logic [7:0] CH_ASTERISK  = 8'h2A;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_LANGLE    = 8'h3C;
   localparam logic [7:0] CH_RANGLE    = 8'h3E;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   localparam logic [7:0] LEN_MAX     = 8'd255;
   localparam logic [7:0] CAP_RESET   = 8'd255;
   localparam int         QUEUE_DEPTH = 4;
   localparam int         MAX_TOKENS  = 3;

   // one token
   typedef struct packed {
      logic [23:0] start;
      logic [7:0]  length;
      kind_type    kind;
   } tok_type;

   // all tokens caused by one byte
   typedef struct packed {
      logic [1:0]                   count;
      tok_type [MAX_TOKENS-1:0]     tok;
   } bundle_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
   endfunction

   function automatic logic is_word_mark(input logic [7:0] b);
      return b == CH_UNDERLINE || b == CH_PLUS || b == CH_HASH || b == CH_EQUAL ||
             b == CH_COLON || b == CH_MINUS || b == CH_SLASH;
   endfunction

   // single-byte punctuation; KIND_STRING means none
   function automatic kind_type punct_kind(input logic [7:0] b);
      kind_type k;
      unique case (b)
         CH_PERIOD:   k = KIND_PERIOD;
         CH_ASTERISK: k = KIND_ASTERISK;
         CH_LBRACKET: k = KIND_LBRACKET;
         CH_RBRACKET: k = KIND_RBRACKET;
         CH_LPAREN:   k = KIND_LPAREN;
         CH_RPAREN:   k = KIND_RPAREN;
         CH_LANGLE:   k = KIND_LANGLE;
         CH_RANGLE:   k = KIND_RANGLE;
         default:     k = KIND_STRING;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] sat_inc(input logic [7:0] len);
      return (len == LEN_MAX) ? LEN_MAX : len + 8'd1;
   endfunction

endpackage

// ----- src/pbt_req_if.sv -----
// ----------------------------------------------------------------------------
// pbt_req_if
// Byte channel into the tokenizer: one text byte and its end-of-text flag.
// ----------------------------------------------------------------------------
interface pbt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       last_byte;

   modport source (output valid, output text_byte, output last_byte, input ready);
   modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

// ----- src/pbt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pbt_rsp_if
// Token channel out of the tokenizer.
// ----------------------------------------------------------------------------
interface pbt_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] token_start;
   logic [7:0]  token_length;
   logic [3:0]  token_kind;
   logic        last_of_run;

   modport source (output valid, output token_start, output token_length,
                   output token_kind, output last_of_run, input ready);
   modport sink   (input valid, input token_start, input token_length,
                   input token_kind, input last_of_run, output ready);
endinterface

// ----- src/pbt_front.sv -----
// ----------------------------------------------------------------------------
// pbt_front
// Lexer front end: classifies each accepted byte, updates the lexer state and
// builds the bundle of up to three tokens that the byte causes.
// ----------------------------------------------------------------------------
module pbt_front import pbt_pkg::*; #(
   parameter int POSITION_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] text_byte,
   input  logic       last_byte,
   input  logic [7:0] max_len,
   output bundle_type bundle
);

   mode_type                 mode_ff, mode_in;
   logic                     esc_ff, esc_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] ostart_ff, ostart_in;
   logic [7:0]               olen_ff, olen_in;
   logic                     dig_ff, dig_in;

   // outcome of lexing the byte from the idle mode
   logic     id_emit, id_open, id_word, id_dig;
   tok_type  id_tok;
   mode_type id_mode;
   kind_type id_kind, pk;
   logic [23:0] pos_start, next_start;
   logic [POSITION_BITS-1:0] pos_next;
   logic [7:0] len_inc;
   logic       relex, closed;
   bundle_type bun;

   function automatic logic [23:0] to_start(input logic [31:0] p);
      return p[23:0];
   endfunction

   function automatic bundle_type put(input bundle_type b, input tok_type t);
      bundle_type r;
      r = b;
      r.tok[b.count] = t;
      r.count = b.count + 2'd1;
      return r;
   endfunction

   assign pos_next   = pos_ff + POSITION_BITS'(1);
   assign pos_start  = to_start(32'(pos_ff));
   assign next_start = to_start(32'(pos_next));
   assign len_inc    = sat_inc(olen_ff);
   assign pk         = punct_kind(text_byte);

   // idle-mode lexing of the current byte
   always_comb begin
      id_emit = 1'b0;
      id_open = 1'b0;
      id_word = 1'b0;
      id_dig  = is_digit(text_byte);
      id_mode = MODE_IDLE;
      id_kind = KIND_SYMBOL;
      id_tok  = '{start: pos_start, length: 8'd1, kind: pk};
      if (is_space(text_byte)) begin
         id_emit = 1'b0;
      end else if (pk != KIND_STRING) begin
         id_emit = 1'b1;
      end else if (text_byte == CH_QUOTE || text_byte == CH_DOLLAR ||
                   is_digit(text_byte) || is_alpha(text_byte)) begin
         id_open = 1'b1;
         if (text_byte == CH_QUOTE) begin
            id_mode = MODE_STRING;
            id_kind = KIND_STRING;
         end else if (text_byte == CH_DOLLAR) begin
            id_mode = MODE_NAG;
            id_kind = KIND_NAG;
         end else begin
            id_mode = MODE_WORD;
            id_word = 1'b1;
            id_kind = id_dig ? KIND_INTEGER : KIND_SYMBOL;
         end
         // a cap of one or less closes the new token at once (never a NAG)
         if (text_byte != CH_DOLLAR && max_len <= 8'd1) begin
            id_emit = 1'b1;
            id_tok  = '{start: pos_start, length: 8'd1, kind: id_kind};
            id_mode = MODE_IDLE;
         end
      end
   end

   // lexer state update and token bundle
   always_comb begin
      mode_in   = mode_ff;
      esc_in    = esc_ff;
      ostart_in = ostart_ff;
      olen_in   = olen_ff;
      dig_in    = dig_ff;
      pos_in    = pos_next;
      relex     = 1'b0;
      closed    = 1'b0;
      bun       = '0;

      unique case (mode_ff)
         MODE_STRING: begin
            olen_in = len_inc;
            if (esc_ff) begin
               esc_in = 1'b0;
            end else if (text_byte == CH_BACKSLASH) begin
               esc_in = 1'b1;
            end else if (text_byte == CH_QUOTE) begin
               closed = 1'b1;
            end
            if (closed || len_inc >= max_len) begin
               bun     = put(bun, '{start: to_start(32'(ostart_ff)), length: len_inc,
                                    kind: KIND_STRING});
               mode_in = MODE_IDLE;
               esc_in  = 1'b0;
            end
         end
         MODE_NAG: begin
            if (is_space(text_byte) || is_digit(text_byte)) begin
               olen_in = len_inc;
            end else begin
               bun     = put(bun, '{start: to_start(32'(ostart_ff)), length: olen_ff,
                                    kind: KIND_NAG});
               mode_in = MODE_IDLE;
               esc_in  = 1'b0;
               relex   = 1'b1;
            end
         end
         MODE_WORD: begin
            if (is_digit(text_byte) || is_alpha(text_byte) || is_word_mark(text_byte)) begin
               olen_in = len_inc;
               dig_in  = dig_ff & is_digit(text_byte);
               if (len_inc >= max_len) begin
                  bun     = put(bun, '{start: to_start(32'(ostart_ff)), length: len_inc,
                                       kind: dig_in ? KIND_INTEGER : KIND_SYMBOL});
                  mode_in = MODE_IDLE;
                  esc_in  = 1'b0;
               end
            end else begin
               bun     = put(bun, '{start: to_start(32'(ostart_ff)), length: olen_ff,
                                    kind: dig_ff ? KIND_INTEGER : KIND_SYMBOL});
               mode_in = MODE_IDLE;
               esc_in  = 1'b0;
               relex   = 1'b1;
            end
         end
         default: begin
            relex = 1'b1;
         end
      endcase

      // the byte that ended a NAG or word, or a byte met in idle mode, is lexed from idle
      if (relex) begin
         if (id_emit) begin
            bun = put(bun, id_tok);
         end
         mode_in = id_mode;
         if (id_open) begin
            ostart_in = pos_ff;
            olen_in   = 8'd1;
            esc_in    = 1'b0;
            if (id_word) begin
               dig_in = id_dig;
            end
         end
      end

      // end of text: flush the open token, then the end marker
      if (last_byte) begin
         if (mode_in != MODE_IDLE) begin
            bun = put(bun, '{start: to_start(32'(ostart_in)), length: olen_in,
                             kind: (mode_in == MODE_STRING) ? KIND_STRING :
                                   (mode_in == MODE_NAG) ? KIND_NAG :
                                   dig_in ? KIND_INTEGER : KIND_SYMBOL});
         end
         bun       = put(bun, '{start: next_start, length: 8'd0, kind: KIND_END});
         mode_in   = MODE_IDLE;
         esc_in    = 1'b0;
         pos_in    = '0;
         ostart_in = '0;
         olen_in   = 8'd0;
         dig_in    = 1'b0;
      end
   end

   assign bundle = bun;

   // lexer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         esc_ff    <= 1'b0;
         pos_ff    <= '0;
         ostart_ff <= '0;
         olen_ff   <= 8'd0;
         dig_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         esc_ff    <= esc_in;
         pos_ff    <= pos_in;
         ostart_ff <= ostart_in;
         olen_ff   <= olen_in;
         dig_ff    <= dig_in;
      end
   end

   // end of text always restarts the lexer at offset zero
   a_restart: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> mode_ff == MODE_IDLE && pos_ff == '0 && !esc_ff)
      else $error("lexer not restarted after end of text");

   // escapes only live inside strings
   a_esc_mode: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> mode_ff == MODE_STRING)
      else $error("escape pending outside a string");

endmodule

// ----- src/pbt_queue.sv -----
// ----------------------------------------------------------------------------
// pbt_queue
// Small queue of token bundles between the lexer and the output stage.
// ----------------------------------------------------------------------------
module pbt_queue import pbt_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   input  logic       pop,
   output bundle_type head,
   output logic       empty,
   output logic       full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bundle_type          mem_ff [DEPTH];
   logic [PW-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]       cnt_ff, cnt_in;

   assign empty = (cnt_ff == CW'(0));
   assign full  = (cnt_ff == CW'(DEPTH));
   assign head  = mem_ff[rd_ff];

   // pointer and fill count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("bundle pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("bundle popped from an empty queue");

endmodule

// ----- src/pbt_back.sv -----
// ----------------------------------------------------------------------------
// pbt_back
// Output stage: unpacks queued bundles and sends one token per cycle, while
// rsp is ready and the queue is not empty, through an output register.
// ----------------------------------------------------------------------------
module pbt_back import pbt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  bundle_type   head,
   input  logic         empty,
   output logic         pop,
   pbt_rsp_if.source    rsp
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   tok_type    tok_ff;
   logic       last_ff;
   logic       load, at_last;

   assign load    = !empty && (!valid_ff || rsp.ready);
   assign at_last = (idx_ff == head.count - 2'd1);
   assign pop     = load && at_last;

   // token index within the head bundle, output valid
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = at_last ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff  <= head.tok[idx_ff];
         last_ff <= at_last;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.token_start  = tok_ff.start;
   assign rsp.token_length = tok_ff.length;
   assign rsp.token_kind   = tok_ff.kind;
   assign rsp.last_of_run  = last_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> idx_ff < head.count)
      else $error("token index past the end of its bundle");

endmodule

// ----- src/pgn_byte_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// pgn_byte_tokenizer_top
// PGN text tokenizer: bytes in, tokens (start, length, kind) out.
// ----------------------------------------------------------------------------
// The block takes one text byte per clock cycle on req while the queue has
// room, and gives tokens on rsp, one token per cycle while rsp is ready. The
// first token of a byte passes through the queue and then the output
// register before it is valid on rsp.
// The lexer decides every byte combinationally; the tokens a byte causes
// (up to three: a closed token, a punctuation or capped token, an end marker)
// travel as one bundle through a four-entry queue to the output register.
// Bytes are taken back to back as long as that queue has room, so the
// sustained byte rate is one per cycle while bytes produce at most one token
// on average; bursts of multi-token bytes are absorbed by the queue and
// otherwise limited by the one-token-per-cycle output register.
// max_token_length sits at byte address 0 of the register port and may only
// be written while no text is in flight.
// ----------------------------------------------------------------------------
module pgn_byte_tokenizer_top import pbt_pkg::*; #(
   parameter int POSITION_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   pbt_req_if.sink     req,
   pbt_rsp_if.source   rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic       cap_sel;
   logic [7:0] cap_ff;
   logic       accept, push, pop, q_empty, q_full;
   bundle_type bundle, head;

   // register port
   assign pready  = 1'b1;
   assign cap_sel = (paddr[2] == 1'b0);
   assign prdata  = cap_sel ? {24'd0, cap_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (psel && penable && pwrite && cap_sel) begin
         cap_ff <= pwdata[7:0];
      end
   end

   // bytes are taken whenever the queue can hold another bundle
   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign push      = accept && (bundle.count != 2'd0);

   pbt_front #(
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req.text_byte),
      .last_byte (req.last_byte),
      .max_len   (cap_ff),
      .bundle    (bundle)
   );

   pbt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (bundle),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   pbt_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (q_empty),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule
